FILE: hdl/tpmd_pkg.sv
// shared types, widths and constants of the track pair mean distance block
package tpmd_pkg;

    // fixed field widths
    localparam int COORD_W = 32;
    localparam int DIFF_W  = 32;
    localparam int HALF_W  = 16;
    localparam int SQ_W    = 66;
    localparam int ROOT_W  = 33;
    localparam int REM_W   = 35;
    localparam int MEAN_W  = 33;

    // partial products per plane: three for dx squared, three for dy squared
    localparam int MUL_STEPS = 6;

    // depth of the queue between classifier and arithmetic
    localparam int JOB_DEPTH = 2;

    // default plane limit per track pair
    localparam int MAX_PLANES_DEF = 8;

    // reset value of the limit register, 100000.0 in 1/16 units
    localparam logic signed [COORD_W-1:0] VALID_LIMIT_RST = 32'sd1600000;

    // one input item
    typedef struct packed {
        logic signed [COORD_W-1:0] track_a_x;
        logic signed [COORD_W-1:0] track_a_y;
        logic signed [COORD_W-1:0] track_b_x;
        logic signed [COORD_W-1:0] track_b_y;
        logic                      last_plane;
    } t_in_item;

    // one result item
    typedef struct packed {
        logic [MEAN_W-1:0] mean_distance;
        logic              no_valid_plane;
    } t_out_item;

    // classified plane handed from front to back
    typedef struct packed {
        logic [DIFF_W-1:0] dx;
        logic [DIFF_W-1:0] dy;
        logic              counted;
        logic              last;
    } t_job;

endpackage

FILE: hdl/tpmd_fifo.sv
// small register queue between the classifier and the arithmetic back end
module tpmd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr;
    logic [PTR_W-1:0] n_rd;
    logic             do_push;
    logic             do_pop;

    // status
    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    // pointer wrap
    assign n_wr = (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
    assign n_rd = (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;

    // storage and pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) begin
                r_mem[r_wr] <= i_data;
                r_wr        <= n_wr;
            end
            if (do_pop) begin
                r_rd <= n_rd;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

FILE: hdl/tpmd_front.sv
// front end: limit register, plane counting, validity check and coordinate differences
module tpmd_front import tpmd_pkg::*; #(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic signed [COORD_W-1:0] i_cfg_data,
    input  logic                      i_push,
    output logic                      o_full,
    input  t_in_item                  i_item,
    output logic                      o_job_push,
    output t_job                      o_job,
    input  logic                      i_job_full
);

    localparam int IDX_W = $clog2(MAX_PLANES + 1);

    logic signed [COORD_W-1:0] r_limit;
    logic [IDX_W-1:0]          r_index;
    logic [IDX_W-1:0]          n_index;
    logic                      accept;
    logic                      in_range;
    logic                      plane_ok;
    logic [COORD_W:0]          diff_x;
    logic [COORD_W:0]          diff_y;
    logic [COORD_W:0]          mag_x;
    logic [COORD_W:0]          mag_y;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_job_full;
    assign accept      = i_push && !i_job_full;

    // plane is usable when inside the plane budget and all points below the limit
    assign in_range = (r_index < IDX_W'(MAX_PLANES));
    assign plane_ok = in_range &&
                      (i_item.track_a_x < r_limit) && (i_item.track_a_y < r_limit) &&
                      (i_item.track_b_x < r_limit) && (i_item.track_b_y < r_limit);

    // exact differences, then magnitudes (always fit 32 bits)
    assign diff_x = {i_item.track_b_x[COORD_W-1], i_item.track_b_x} -
                    {i_item.track_a_x[COORD_W-1], i_item.track_a_x};
    assign diff_y = {i_item.track_b_y[COORD_W-1], i_item.track_b_y} -
                    {i_item.track_a_y[COORD_W-1], i_item.track_a_y};
    assign mag_x  = diff_x[COORD_W] ? (~diff_x + 1'b1) : diff_x;
    assign mag_y  = diff_y[COORD_W] ? (~diff_y + 1'b1) : diff_y;

    // only counted planes and pair ends need the back end
    assign o_job_push    = accept && (plane_ok || i_item.last_plane);
    assign o_job.dx      = mag_x[DIFF_W-1:0];
    assign o_job.dy      = mag_y[DIFF_W-1:0];
    assign o_job.counted = plane_ok;
    assign o_job.last    = i_item.last_plane;

    // plane index saturates at the budget and clears at the pair end
    always_comb begin
        if (i_item.last_plane) begin
            n_index = '0;
        end else if (in_range) begin
            n_index = r_index + 1'b1;
        end else begin
            n_index = r_index;
        end
    end

    // limit register and plane index
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit <= VALID_LIMIT_RST;
            r_index <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (accept) begin
                r_index <= n_index;
            end
        end
    end

endmodule

FILE: hdl/tpmd_back.sv
// back end: squared distance, bit-serial square root, running sum and mean division
module tpmd_back import tpmd_pkg::*; #(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_job_empty,
    output logic      o_job_pop,
    input  t_job      i_job,
    input  logic      i_pop,
    output logic      o_empty,
    output t_out_item o_result
);

    localparam int CW    = $clog2(MAX_PLANES + 1);
    localparam int TOTW  = ROOT_W + $clog2(MAX_PLANES);
    localparam int CNT_W = $clog2(TOTW + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ROOT,
        S_DIV,
        S_DONE
    } t_state;

    t_state            r_state,     n_state;
    logic [CNT_W-1:0]  r_step,      n_step;
    logic [DIFF_W-1:0] r_x,         n_x;
    logic [DIFF_W-1:0] r_y,         n_y;
    logic [SQ_W-1:0]   r_rad,       n_rad;
    logic [REM_W-1:0]  r_rem,       n_rem;
    logic [ROOT_W-1:0] r_root,      n_root;
    logic [TOTW-1:0]   r_total,     n_total;
    logic [CW-1:0]     r_count,     n_count;
    logic [TOTW-1:0]   r_quo,       n_quo;
    logic [CW-1:0]     r_drem,      n_drem;
    logic              r_none,      n_none;
    logic              r_last,      n_last;
    logic              r_out_valid, n_out_valid;
    t_out_item         r_result,    n_result;

    logic [HALF_W-1:0]  op_a;
    logic [HALF_W-1:0]  op_b;
    logic [1:0]         op_shift;
    logic [2*HALF_W-1:0] prod;
    logic [SQ_W-1:0]    term;
    logic [REM_W+1:0]   rem_sh;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   rem_diff;
    logic               root_ge;
    logic [ROOT_W-1:0]  root_next;
    logic [TOTW-1:0]    total_sum;
    logic [CW:0]        drem_sh;
    logic [CW:0]        drem_diff;
    logic               div_ge;

    assign o_empty  = !r_out_valid;
    assign o_result = r_result;

    // partial product selection: low*low, high*low (times two), high*high per axis
    always_comb begin
        case (r_step)
            CNT_W'(0): begin
                op_a = r_x[HALF_W-1:0];      op_b = r_x[HALF_W-1:0];      op_shift = 2'd0;
            end
            CNT_W'(1): begin
                op_a = r_x[DIFF_W-1:HALF_W]; op_b = r_x[HALF_W-1:0];      op_shift = 2'd1;
            end
            CNT_W'(2): begin
                op_a = r_x[DIFF_W-1:HALF_W]; op_b = r_x[DIFF_W-1:HALF_W]; op_shift = 2'd2;
            end
            CNT_W'(3): begin
                op_a = r_y[HALF_W-1:0];      op_b = r_y[HALF_W-1:0];      op_shift = 2'd0;
            end
            CNT_W'(4): begin
                op_a = r_y[DIFF_W-1:HALF_W]; op_b = r_y[HALF_W-1:0];      op_shift = 2'd1;
            end
            default: begin
                op_a = r_y[DIFF_W-1:HALF_W]; op_b = r_y[DIFF_W-1:HALF_W]; op_shift = 2'd2;
            end
        endcase
    end

    // one 16x16 product per cycle, placed at its weight
    assign prod = op_a * op_b;
    always_comb begin
        case (op_shift)
            2'd0:    term = {{(SQ_W - 2*HALF_W){1'b0}}, prod};
            2'd1:    term = {{(SQ_W - 2*HALF_W - HALF_W - 1){1'b0}}, prod, {(HALF_W + 1){1'b0}}};
            default: term = {{(SQ_W - 4*HALF_W){1'b0}}, prod, {(2*HALF_W){1'b0}}};
        endcase
    end

    // square root step: two radicand bits in, one root bit out
    assign rem_sh    = {r_rem, r_rad[SQ_W-1:SQ_W-2]};
    assign trial     = {2'b00, r_root, 2'b01};
    assign root_ge   = (rem_sh >= trial);
    assign rem_diff  = rem_sh - trial;
    assign root_next = {r_root[ROOT_W-2:0], root_ge};
    assign total_sum = r_total + TOTW'(root_next);

    // restoring division step of the total by the plane count
    assign drem_sh   = {r_drem, r_quo[TOTW-1]};
    assign div_ge    = (drem_sh >= {1'b0, r_count});
    assign drem_diff = drem_sh - {1'b0, r_count};

    // sequencer
    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_x         = r_x;
        n_y         = r_y;
        n_rad       = r_rad;
        n_rem       = r_rem;
        n_root      = r_root;
        n_total     = r_total;
        n_count     = r_count;
        n_quo       = r_quo;
        n_drem      = r_drem;
        n_none      = r_none;
        n_last      = r_last;
        n_out_valid = r_out_valid;
        n_result    = r_result;
        o_job_pop   = 1'b0;

        if (i_pop && r_out_valid) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    n_last    = i_job.last;
                    if (i_job.counted) begin
                        n_x     = i_job.dx;
                        n_y     = i_job.dy;
                        n_rad   = '0;
                        n_rem   = '0;
                        n_root  = '0;
                        n_step  = '0;
                        n_state = S_MUL;
                    end else if (i_job.last) begin
                        if (r_count == '0) begin
                            n_quo   = '0;
                            n_none  = 1'b1;
                            n_state = S_DONE;
                        end else begin
                            n_quo   = r_total;
                            n_drem  = '0;
                            n_none  = 1'b0;
                            n_step  = '0;
                            n_state = S_DIV;
                        end
                    end
                end
            end
            S_MUL: begin
                n_rad  = r_rad + term;
                n_step = r_step + 1'b1;
                if (r_step == CNT_W'(MUL_STEPS - 1)) begin
                    n_step  = '0;
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                n_rad  = {r_rad[SQ_W-3:0], 2'b00};
                n_rem  = root_ge ? rem_diff[REM_W-1:0] : rem_sh[REM_W-1:0];
                n_root = root_next;
                n_step = r_step + 1'b1;
                if (r_step == CNT_W'(ROOT_W - 1)) begin
                    n_total = total_sum;
                    n_count = r_count + 1'b1;
                    n_step  = '0;
                    if (r_last) begin
                        n_quo   = total_sum;
                        n_drem  = '0;
                        n_none  = 1'b0;
                        n_state = S_DIV;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            S_DIV: begin
                n_quo  = {r_quo[TOTW-2:0], div_ge};
                n_drem = div_ge ? drem_diff[CW-1:0] : drem_sh[CW-1:0];
                n_step = r_step + 1'b1;
                if (r_step == CNT_W'(TOTW - 1)) begin
                    n_step  = '0;
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_pop) begin
                    n_result.mean_distance  = r_quo[MEAN_W-1:0];
                    n_result.no_valid_plane = r_none;
                    n_out_valid             = 1'b1;
                    n_total                 = '0;
                    n_count                 = '0;
                    n_state                 = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_total     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_x         <= n_x;
            r_y         <= n_y;
            r_rad       <= n_rad;
            r_rem       <= n_rem;
            r_root      <= n_root;
            r_total     <= n_total;
            r_count     <= n_count;
            r_quo       <= n_quo;
            r_drem      <= n_drem;
            r_none      <= n_none;
            r_last      <= n_last;
            r_out_valid <= n_out_valid;
            r_result    <= n_result;
        end
    end

endmodule

FILE: hdl/track_pair_mean_distance.sv
// top level of the track pair mean distance block
//
// Items are the points of two tracks at one measurement plane, pushed with
// push while full is low. The item with last_plane set closes the pair and
// yields one result: the floored mean of the floored plane distances, or
// no_valid_plane when no plane counted. The result waits on o_result while
// empty is low and leaves with pop. The limit register is written over the
// cfg valid/ready channel, which is always ready.
// A plane that does not count needs no arithmetic in the back end. A counted
// plane costs the back end six 16x16 partial products for the squared
// distance, then one root bit per cycle. Closing a pair with counted planes
// adds one division step per total bit (36 at eight planes) plus a final step
// to load the result register. A two-entry queue lets the front accept
// while the back end works. While a result waits unread the back end stalls
// before loading the next one, and items queue up until full rises.
// Reset clears the running sum, the counts, the job queue and the waiting
// result, and sets the limit to 1600000 (100000.0 in 1/16 units).
module track_pair_mean_distance import tpmd_pkg::*; #(
    parameter int MAX_PLANES = MAX_PLANES_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_valid,
    output logic                      o_cfg_ready,
    input  logic signed [COORD_W-1:0] i_cfg_data,
    input  logic                      push,
    output logic                      full,
    input  t_in_item                  i_item,
    output logic                      empty,
    input  logic                      pop,
    output t_out_item                 o_result
);

    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    t_job job_in;
    t_job job_out;

    // classification
    tpmd_front #(
        .MAX_PLANES (MAX_PLANES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data),
        .i_push      (push),
        .o_full      (full),
        .i_item      (i_item),
        .o_job_push  (job_push),
        .o_job       (job_in),
        .i_job_full  (job_full)
    );

    // decoupling queue
    tpmd_fifo #(
        .WIDTH ($bits(t_job)),
        .DEPTH (JOB_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .i_data  (job_in),
        .o_full  (job_full),
        .i_pop   (job_pop),
        .o_data  (job_out),
        .o_empty (job_empty)
    );

    // arithmetic
    tpmd_back #(
        .MAX_PLANES (MAX_PLANES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job       (job_out),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_result    (o_result)
    );

endmodule
